>>> rtl/vac_pkg.sv
package vac_pkg;

  localparam int COMP_W  = 24;
  localparam int SC_W    = 31;
  localparam int PROD_W  = 2 * SC_W;
  localparam int SUM_W   = 64;
  localparam int DM_W    = 30;
  localparam int RAD_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int REM_W   = 33;
  localparam int CV_W    = 36;
  localparam int CZ_W    = 34;
  localparam int ANG_W   = 18;
  localparam int TOLSQ_W = 48;
  localparam int SNAP_W  = 16;
  localparam int ISQ_N   = ROOT_W;
  localparam int CORDIC_N = 28;

  localparam logic [ANG_W-1:0]       PI_Q16      = 18'd205887;
  localparam logic [ANG_W-1:0]       HALF_PI_Q16 = 18'd102944;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef enum logic [1:0] {
    REG_SQR_POINT_TOL = 2'd0,
    REG_SNAP_TOL      = 2'd1,
    REG_ANG_MARGIN    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_DIFFERENT = 2'd0,
    DIR_SAME      = 2'd1,
    DIR_OPPOSITE  = 2'd2
  } dir_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] a_x;
    logic signed [COMP_W-1:0] a_y;
    logic signed [COMP_W-1:0] a_z;
    logic signed [COMP_W-1:0] b_x;
    logic signed [COMP_W-1:0] b_y;
    logic signed [COMP_W-1:0] b_z;
  } in_item_t;

  typedef struct packed {
    logic             angle_defined;
    logic [ANG_W-1:0] angle_rad;
    logic             is_parallel;
    logic [1:0]       direction_code;
    logic             is_perpendicular;
  } out_item_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } isq_st_t;

  typedef struct packed {
    logic [DM_W-1:0] d_mag;
    logic            d_neg;
    logic            dt_neg;
    logic            defined;
  } side_t;

  typedef struct packed {
    logic signed [CV_W-1:0] x;
    logic signed [CV_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } crd_st_t;

  function automatic logic signed [CZ_W-1:0] atan_q30(input int i);
    logic signed [CZ_W-1:0] a;
    case (i)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021688;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      23: a = 34'sd128;
      24: a = 34'sd64;
      25: a = 34'sd32;
      26: a = 34'sd16;
      27: a = 34'sd8;
      default: a = '0;
    endcase
    return a;
  endfunction

  // position of the highest set bit, zero for zero
  function automatic logic [6:0] msb_pos(input logic [63:0] v);
    logic [6:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 7'(i);
    end
    return p;
  endfunction

endpackage

>>> rtl/vac_isqrt_cell.sv
module vac_isqrt_cell import vac_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_v,
  input  isq_st_t in_st,
  input  side_t   in_side,
  output logic    out_v,
  output isq_st_t out_st,
  output side_t   out_side
);

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             ge;
  isq_st_t          st_nxt;
  logic             v_r;
  isq_st_t          st_r;
  side_t            side_r;

  // one result bit per cell: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh = {in_st.rem, in_st.rad[RAD_W-1 -: 2]};
    trial  = (REM_W+2)'({in_st.root, 2'b01});
    ge     = (rem_sh >= trial);
    st_nxt.rem  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    st_nxt.root = {in_st.root[ROOT_W-2:0], ge};
    st_nxt.rad  = {in_st.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    side_r <= in_side;
  end

  assign out_v    = v_r;
  assign out_st   = st_r;
  assign out_side = side_r;

endmodule

>>> rtl/vac_cordic_cell.sv
module vac_cordic_cell import vac_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  crd_st_t in_st,
  output crd_st_t out_st
);

  crd_st_t st_nxt;
  crd_st_t st_r;

  generate
    if (STEP < CORDIC_N) begin : g_rot
      logic signed [CV_W-1:0] xs;
      logic signed [CV_W-1:0] ys;
      always_comb begin
        xs = in_st.x >>> STEP;
        ys = in_st.y >>> STEP;
        if (!in_st.y[CV_W-1]) begin
          st_nxt.x = in_st.x + ys;
          st_nxt.y = in_st.y - xs;
          st_nxt.z = in_st.z + atan_q30(STEP);
        end else begin
          st_nxt.x = in_st.x - ys;
          st_nxt.y = in_st.y + xs;
          st_nxt.z = in_st.z - atan_q30(STEP);
        end
      end
    end else begin : g_hold
      // trailing cells only keep pace with the square root chain
      always_comb begin
        st_nxt = in_st;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_st = st_r;

endmodule

>>> rtl/vector_angle_classify.sv
// Channel  Ports                          Direction  Handshake
// input    start, busy, in_data           in         item taken when start & !busy
// result   out_valid, out_data            out        one-cycle strobe, no back-pressure
// config   cfg_valid, cfg_ready, cfg_*    in         write when cfg_valid & cfg_ready
//
// One item enters every cycle; busy stays low. Each result passes through two 31-cell
// square root chains (one cell per root bit), the CORDIC cells running beside the second,
// and eleven arithmetic stages.
// Reset is synchronous, active low, clears the valid bits and sets the config defaults.
// The receiver cannot stall, so nothing is held back anywhere in the pipeline.
module vector_angle_classify import vac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [TOLSQ_W-1:0] cfg_data
);

  localparam int LAT = 7 + 2 * ISQ_N + 4;

  logic in_acc;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_acc    = start & ~busy;

  // configuration
  logic [TOLSQ_W-1:0] sqr_tol_r;
  logic [SNAP_W-1:0]  snap_tol_r;
  logic [ANG_W-1:0]   ang_margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqr_tol_r    <= '0;
      snap_tol_r   <= 16'd1;
      ang_margin_r <= 18'd655;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SQR_POINT_TOL: sqr_tol_r    <= cfg_data;
        REG_SNAP_TOL:      snap_tol_r   <= cfg_data[SNAP_W-1:0];
        REG_ANG_MARGIN:    ang_margin_r <= cfg_data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: register components and their squares
  logic signed [COMP_W-1:0] comp_w [6];
  logic [COMP_W-1:0]        mag_in_w [6];
  logic signed [COMP_W-1:0] comp1_r [6];
  logic [2*COMP_W-1:0]      sq1_r [6];
  logic                     v1_r;

  assign comp_w[0] = in_data.a_x;
  assign comp_w[1] = in_data.a_y;
  assign comp_w[2] = in_data.a_z;
  assign comp_w[3] = in_data.b_x;
  assign comp_w[4] = in_data.b_y;
  assign comp_w[5] = in_data.b_z;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mag_in_w[i] = comp_w[i][COMP_W-1] ? COMP_W'(-comp_w[i]) : COMP_W'(comp_w[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      comp1_r[i] <= comp_w[i];
      sq1_r[i]   <= mag_in_w[i] * mag_in_w[i];
    end
  end

  // stage 2: degenerate test, scale each nonzero vector to a top part in [2^29, 2^30)
  logic [63:0]             ma_w, mb_w;
  logic [COMP_W-1:0]       mg_w [6];
  logic [COMP_W-1:0]       mx_w [2];
  logic [6:0]              p_w [2];
  logic [63:0]             sm_w [6];
  logic signed [SC_W-1:0]  sc_w [6];
  logic signed [SC_W-1:0]  sc2_r [6];
  logic                    def2_r;
  logic                    v2_r;

  always_comb begin
    ma_w = 64'(sq1_r[0]) + 64'(sq1_r[1]) + 64'(sq1_r[2]);
    mb_w = 64'(sq1_r[3]) + 64'(sq1_r[4]) + 64'(sq1_r[5]);
    for (int i = 0; i < 6; i++) begin
      mg_w[i] = comp1_r[i][COMP_W-1] ? COMP_W'(-comp1_r[i]) : COMP_W'(comp1_r[i]);
    end
    for (int k = 0; k < 2; k++) begin
      mx_w[k] = mg_w[3*k];
      if (mg_w[3*k+1] > mx_w[k]) mx_w[k] = mg_w[3*k+1];
      if (mg_w[3*k+2] > mx_w[k]) mx_w[k] = mg_w[3*k+2];
      p_w[k] = msb_pos(64'(mx_w[k]));
    end
    for (int i = 0; i < 6; i++) begin
      // right shifts act on the magnitude, so they truncate toward zero
      if (p_w[i/3] >= 7'd30) sm_w[i] = 64'(mg_w[i]) >> (p_w[i/3] - 7'd29);
      else                   sm_w[i] = 64'(mg_w[i]) << (7'd29 - p_w[i/3]);
      sc_w[i] = comp1_r[i][COMP_W-1] ? -$signed(sm_w[i][SC_W-1:0])
                                      : $signed(sm_w[i][SC_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    sc2_r  <= sc_w;
    def2_r <= (ma_w > 64'(sqr_tol_r)) && (mb_w > 64'(sqr_tol_r));
  end

  // stage 3: dot and cross partial products
  logic signed [PROD_W-1:0] pr3_r [9];
  logic                     def3_r;
  logic                     v3_r;

  always_ff @(posedge clk) begin
    pr3_r[0] <= sc2_r[0] * sc2_r[3];
    pr3_r[1] <= sc2_r[1] * sc2_r[4];
    pr3_r[2] <= sc2_r[2] * sc2_r[5];
    pr3_r[3] <= sc2_r[1] * sc2_r[5];
    pr3_r[4] <= sc2_r[2] * sc2_r[4];
    pr3_r[5] <= sc2_r[2] * sc2_r[3];
    pr3_r[6] <= sc2_r[0] * sc2_r[5];
    pr3_r[7] <= sc2_r[0] * sc2_r[4];
    pr3_r[8] <= sc2_r[1] * sc2_r[3];
    def3_r   <= def2_r;
  end

  // stage 4: sums
  logic signed [SUM_W-1:0] dt4_r, cx4_r, cy4_r, cz4_r;
  logic                    def4_r;
  logic                    v4_r;

  always_ff @(posedge clk) begin
    dt4_r  <= SUM_W'(pr3_r[0]) + SUM_W'(pr3_r[1]) + SUM_W'(pr3_r[2]);
    cx4_r  <= SUM_W'(pr3_r[3]) - SUM_W'(pr3_r[4]);
    cy4_r  <= SUM_W'(pr3_r[5]) - SUM_W'(pr3_r[6]);
    cz4_r  <= SUM_W'(pr3_r[7]) - SUM_W'(pr3_r[8]);
    def4_r <= def3_r;
  end

  // stage 5: common shift bringing all four magnitudes below 2^30
  logic [SUM_W-1:0] m4_w [4];
  logic [SUM_W-1:0] mmax_w;
  logic [6:0]       pm_w;
  logic [6:0]       s_w;
  logic [DM_W-1:0]  dm_w [4];
  logic [DM_W-1:0]  cm5_r [3];
  side_t            side5_r;
  logic             v5_r;

  always_comb begin
    m4_w[0] = dt4_r[SUM_W-1] ? SUM_W'(-dt4_r) : SUM_W'(dt4_r);
    m4_w[1] = cx4_r[SUM_W-1] ? SUM_W'(-cx4_r) : SUM_W'(cx4_r);
    m4_w[2] = cy4_r[SUM_W-1] ? SUM_W'(-cy4_r) : SUM_W'(cy4_r);
    m4_w[3] = cz4_r[SUM_W-1] ? SUM_W'(-cz4_r) : SUM_W'(cz4_r);
    mmax_w = m4_w[0];
    for (int i = 1; i < 4; i++) begin
      if (m4_w[i] > mmax_w) mmax_w = m4_w[i];
    end
    pm_w = msb_pos(mmax_w);
    s_w  = (pm_w >= 7'd30) ? (pm_w - 7'd29) : 7'd0;
    for (int i = 0; i < 4; i++) begin
      dm_w[i] = DM_W'(m4_w[i] >> s_w);
    end
  end

  always_ff @(posedge clk) begin
    cm5_r[0]       <= dm_w[1];
    cm5_r[1]       <= dm_w[2];
    cm5_r[2]       <= dm_w[3];
    side5_r.d_mag   <= dm_w[0];
    side5_r.dt_neg  <= dt4_r[SUM_W-1];
    side5_r.d_neg   <= dt4_r[SUM_W-1] && (dm_w[0] != '0);
    side5_r.defined <= def4_r;
  end

  // stage 6: cross squares
  logic [2*DM_W-1:0] csq6_r [3];
  side_t             side6_r;
  logic              v6_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      csq6_r[i] <= cm5_r[i] * cm5_r[i];
    end
    side6_r <= side5_r;
  end

  // stage 7: radicand of |cross|
  logic [RAD_W-1:0] rad7_r;
  side_t            side7_r;
  logic             v7_r;

  always_ff @(posedge clk) begin
    rad7_r  <= RAD_W'(csq6_r[0]) + RAD_W'(csq6_r[1]) + RAD_W'(csq6_r[2]);
    side7_r <= side6_r;
  end

  // chain A: r = isqrt(|cross|^2)
  logic    a_v    [ISQ_N+1];
  isq_st_t a_st   [ISQ_N+1];
  side_t   a_side [ISQ_N+1];

  assign a_v[0]         = v7_r;
  assign a_st[0].rad    = rad7_r;
  assign a_st[0].rem    = '0;
  assign a_st[0].root   = '0;
  assign a_side[0]      = side7_r;

  genvar g;
  generate
    for (g = 0; g < ISQ_N; g++) begin : g_chain_a
      vac_isqrt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_v     (a_v[g]),
        .in_st    (a_st[g]),
        .in_side  (a_side[g]),
        .out_v    (a_v[g+1]),
        .out_st   (a_st[g+1]),
        .out_side (a_side[g+1])
      );
    end
  endgenerate

  // stage 8: squares for h, CORDIC entry (quarter turn when d is negative)
  logic [ROOT_W-1:0]   cr_w;
  logic [2*ROOT_W-1:0] crsq8_r;
  logic [2*DM_W-1:0]   dsq8_r;
  crd_st_t             crd8_r;
  side_t               side8_r;
  logic                v8_r;

  assign cr_w = a_st[ISQ_N].root;

  always_ff @(posedge clk) begin
    crsq8_r <= cr_w * cr_w;
    dsq8_r  <= a_side[ISQ_N].d_mag * a_side[ISQ_N].d_mag;
    if (a_side[ISQ_N].d_neg) begin
      crd8_r.x <= CV_W'(cr_w);
      crd8_r.y <= CV_W'(a_side[ISQ_N].d_mag);
      crd8_r.z <= HALF_PI_Q30;
    end else begin
      crd8_r.x <= CV_W'(a_side[ISQ_N].d_mag);
      crd8_r.y <= CV_W'(cr_w);
      crd8_r.z <= '0;
    end
    side8_r <= a_side[ISQ_N];
  end

  // stage 9: radicand of h
  logic [RAD_W-1:0] rad9_r;
  crd_st_t          crd9_r;
  side_t            side9_r;
  logic             v9_r;

  always_ff @(posedge clk) begin
    rad9_r  <= RAD_W'(crsq8_r) + RAD_W'(dsq8_r);
    crd9_r  <= crd8_r;
    side9_r <= side8_r;
  end

  // chain B: h = isqrt(d^2 + r^2), CORDIC alongside
  logic    b_v    [ISQ_N+1];
  isq_st_t b_st   [ISQ_N+1];
  side_t   b_side [ISQ_N+1];
  crd_st_t b_crd  [ISQ_N+1];

  assign b_v[0]       = v9_r;
  assign b_st[0].rad  = rad9_r;
  assign b_st[0].rem  = '0;
  assign b_st[0].root = '0;
  assign b_side[0]    = side9_r;
  assign b_crd[0]     = crd9_r;

  generate
    for (g = 0; g < ISQ_N; g++) begin : g_chain_b
      vac_isqrt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_v     (b_v[g]),
        .in_st    (b_st[g]),
        .in_side  (b_side[g]),
        .out_v    (b_v[g+1]),
        .out_st   (b_st[g+1]),
        .out_side (b_side[g+1])
      );
      vac_cordic_cell #(.STEP(g)) u_crd (
        .clk    (clk),
        .in_st  (b_crd[g]),
        .out_st (b_crd[g+1])
      );
    end
  endgenerate

  // stage E1: snap tests and rounding
  side_t                  se_w;
  logic [SNAP_W:0]        keep_w;
  logic [47:0]            lim_w;
  logic [47:0]            lhs_w;
  logic                   big_w;
  logic signed [CZ_W-1:0] z_w;
  logic signed [CZ_W-1:0] zr_w;
  logic [CZ_W-15:0]       t_w;
  logic [ANG_W-1:0]       ang_w;
  logic [ANG_W-1:0]       ang_e_r;
  logic                   def_e_r;
  logic                   dtneg_e_r;
  logic                   v_e_r;

  always_comb begin
    se_w   = b_side[ISQ_N];
    keep_w = 17'h10000 - (SNAP_W+1)'(snap_tol_r);
    lim_w  = keep_w * b_st[ISQ_N].root;
    lhs_w  = 48'({se_w.d_mag, 16'h0000});
    big_w  = lhs_w > lim_w;
    z_w    = b_crd[ISQ_N].z;
    zr_w   = z_w + 34'sd8192;
    t_w    = zr_w[CZ_W-1:14];
    if (se_w.d_neg && big_w) begin
      ang_w = PI_Q16;
    end else if (!se_w.d_neg && (se_w.d_mag != '0) && big_w) begin
      ang_w = '0;
    end else if (z_w[CZ_W-1] || (z_w == '0)) begin
      ang_w = '0;
    end else if (t_w > (CZ_W-14)'(PI_Q16)) begin
      ang_w = PI_Q16;
    end else begin
      ang_w = t_w[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    ang_e_r   <= ang_w;
    def_e_r   <= se_w.defined;
    dtneg_e_r <= se_w.dt_neg;
  end

  // stage E2: classify and drive the result
  logic      par_w, perp_w;
  out_item_t res_nxt;
  out_item_t out_r;
  logic      out_valid_r;

  always_comb begin
    par_w  = (ang_e_r <= ang_margin_r) || ((PI_Q16 - ang_e_r) <= ang_margin_r);
    perp_w = ({1'b0, ang_e_r} < ({1'b0, HALF_PI_Q16} + {1'b0, ang_margin_r})) &&
             (({1'b0, ang_e_r} + {1'b0, ang_margin_r}) > {1'b0, HALF_PI_Q16});
    res_nxt = '0;
    if (def_e_r) begin
      res_nxt.angle_defined    = 1'b1;
      res_nxt.angle_rad        = ang_e_r;
      res_nxt.is_parallel      = par_w;
      res_nxt.direction_code   = !par_w   ? DIR_DIFFERENT :
                                 dtneg_e_r ? DIR_OPPOSITE : DIR_SAME;
      res_nxt.is_perpendicular = perp_w;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res_nxt;
  end

  // valid bits of the front and back stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      v_e_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_acc;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= a_v[ISQ_N];
      v9_r        <= v8_r;
      v_e_r       <= b_v[ISQ_N];
      out_valid_r <= v_e_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // assertions
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(in_acc && rst_n, LAT))
    else $error("result strobe does not follow its item by the fixed latency");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.angle_defined) |->
      (out_data.angle_rad == '0 && !out_data.is_parallel &&
       out_data.direction_code == DIR_DIFFERENT && !out_data.is_perpendicular))
    else $error("undefined angle carries non-zero fields");

  a_dir_par: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.direction_code != DIR_DIFFERENT) == out_data.is_parallel))
    else $error("direction code disagrees with parallel flag");

  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.angle_rad <= PI_Q16))
    else $error("angle above pi");

endmodule
